// ----- hdl/mau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg: shared types, codes and helpers for the 2x2 matrix arithmetic unit
// Holds the command codes, the stage transaction structs and saturation helpers.
// ----------------------------------------------------------------------------
package mau_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DET = 3'd3;
  localparam logic [2:0] CMD_INV = 3'd4;

  // restoring divider: quotient bits produced per item
  localparam int QuoBits   = 17;
  localparam int DivStages = (QuoBits + 1) / 2;

  // matrix of four Q8.8 elements, index 0 = r0c0, 1 = r0c1, 2 = r1c0, 3 = r1c1
  typedef logic [3:0][15:0] mat_t;

  // product stage transaction
  typedef struct packed {
    logic [2:0]        cmd;
    logic [9:0][31:0]  prod;   // eight matrix products, then a00*a11, a01*a10
    mat_t              addsub; // saturated add or subtract result
    mat_t              a;      // matrix A, kept for the inverse numerators
  } prod_t;

  // fields that ride along the divider
  typedef struct packed {
    logic        inv;   // inverse of a non-singular matrix
    mat_t        res;   // result matrix for every other case
    logic [31:0] det;
    logic        ok;
    logic [31:0] dsr;   // |determinant|
  } side_t;

  // one divider lane
  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] dvd;   // dividend bits still to shift in
    logic [16:0] quo;
    logic        neg;
    logic        ovf;   // quotient magnitude beyond 17 bits
  } lane_t;

  typedef lane_t [3:0] lanes_t;

  function automatic logic [15:0] sat16(input logic signed [33:0] v);
    logic [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'h7fff;
    end else if (v < -34'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/matrix_2x2_arith_unit.sv -----
`timescale 1ns / 1ps
// One transaction per cycle; the inverse runs in a 9-stage restoring divider
// (17 quotient bits, two per stage and one in the last) on four lanes. The
// whole pipeline holds while the output register is full and stalled. Reset
// (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// matrix_2x2_arith_unit: 2x2 signed Q8.8 matrix add, subtract, multiply,
// determinant and inverse, fully pipelined.
// ----------------------------------------------------------------------------
module matrix_2x2_arith_unit import mau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] a_r0c0,
  input  logic [15:0] a_r0c1,
  input  logic [15:0] a_r1c0,
  input  logic [15:0] a_r1c1,
  input  logic [15:0] b_r0c0,
  input  logic [15:0] b_r0c1,
  input  logic [15:0] b_r1c0,
  input  logic [15:0] b_r1c1,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] r_r0c0,
  output logic [15:0] r_r0c1,
  output logic [15:0] r_r1c0,
  output logic [15:0] r_r1c1,
  output logic [31:0] determinant,
  output logic        ok
);

  logic   en;
  mat_t   a;
  mat_t   b;
  logic   p_valid;
  prod_t  p_data;

  logic   [DivStages:0] d_valid;
  side_t  [DivStages:0] d_side;
  lanes_t [DivStages:0] d_lanes;

  mat_t        res_next;
  mat_t        res;
  logic [31:0] det;

  // pipeline advances unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign a = {a_r1c1, a_r1c0, a_r0c1, a_r0c0};
  assign b = {b_r1c1, b_r1c0, b_r0c1, b_r0c0};

  mau_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cmd       (command),
    .a         (a),
    .b         (b),
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  mau_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_data   (p_data),
    .out_valid (d_valid[0]),
    .out_side  (d_side[0]),
    .out_lanes (d_lanes[0])
  );

  // divider stages
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    localparam int Steps = (QuoBits - 2 * g >= 2) ? 2 : 1;
    mau_div_step #(.STEPS(Steps)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d_valid[g]),
      .in_side   (d_side[g]),
      .in_lanes  (d_lanes[g]),
      .out_valid (d_valid[g+1]),
      .out_side  (d_side[g+1]),
      .out_lanes (d_lanes[g+1])
    );
  end

  // sign and saturate the quotients
  always_comb begin
    lane_t l;
    for (int k = 0; k < 4; k++) begin
      l = d_lanes[DivStages][k];
      if (!d_side[DivStages].inv) begin
        res_next[k] = d_side[DivStages].res[k];
      end else if (l.neg) begin
        res_next[k] = (l.ovf || l.quo > 17'd32768) ? 16'h8000 : 16'(-l.quo);
      end else begin
        res_next[k] = (l.ovf || l.quo > 17'd32767) ? 16'h7fff : l.quo[15:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      det <= d_side[DivStages].det;
      ok  <= d_side[DivStages].ok;
    end
  end

  assign r_r0c0      = res[0];
  assign r_r0c1      = res[1];
  assign r_r1c0      = res[2];
  assign r_r1c1      = res[3];
  assign determinant = det;

endmodule

// ----- hdl/mau_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_mult: product stage
// Forms all 16x16 products and the saturated element-wise add or subtract.
// ----------------------------------------------------------------------------
module mau_mult import mau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [2:0] cmd,
  input  mat_t       a,
  input  mat_t       b,
  output logic       out_valid,
  output prod_t      out_data
);

  prod_t data_next;

  // products and add/subtract
  always_comb begin
    logic signed [16:0] s;
    data_next.cmd = cmd;
    data_next.a   = a;
    data_next.prod[0] = $signed(a[0]) * $signed(b[0]);
    data_next.prod[1] = $signed(a[1]) * $signed(b[2]);
    data_next.prod[2] = $signed(a[0]) * $signed(b[1]);
    data_next.prod[3] = $signed(a[1]) * $signed(b[3]);
    data_next.prod[4] = $signed(a[2]) * $signed(b[0]);
    data_next.prod[5] = $signed(a[3]) * $signed(b[2]);
    data_next.prod[6] = $signed(a[2]) * $signed(b[1]);
    data_next.prod[7] = $signed(a[3]) * $signed(b[3]);
    data_next.prod[8] = $signed(a[0]) * $signed(a[3]);
    data_next.prod[9] = $signed(a[1]) * $signed(a[2]);
    for (int k = 0; k < 4; k++) begin
      if (cmd == CMD_SUB) begin
        s = $signed({a[k][15], a[k]}) - $signed({b[k][15], b[k]});
      end else begin
        s = $signed({a[k][15], a[k]}) + $signed({b[k][15], b[k]});
      end
      data_next.addsub[k] = sat16(34'(s));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- hdl/mau_combine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_combine: sum, select and divider setup
// Two register stages: product sums and result select, then divisor and
// numerator magnitudes with the overflow check that seeds the divider.
// ----------------------------------------------------------------------------
module mau_combine import mau_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  prod_t  in_data,
  output logic   out_valid,
  output side_t  out_side,
  output lanes_t out_lanes
);

  // stage 2 registers
  logic                    s2_valid;
  logic                    s2_inv;
  mat_t                    s2_res;
  logic [31:0]             s2_det;
  logic                    s2_ok;
  logic signed [32:0]      s2_d;
  logic [3:0][16:0]        s2_num;

  logic                    s2_inv_next;
  mat_t                    s2_res_next;
  logic [31:0]             s2_det_next;
  logic                    s2_ok_next;
  logic signed [32:0]      s2_d_next;
  logic [3:0][16:0]        s2_num_next;

  side_t                   side_next;
  lanes_t                  lanes_next;

  // product sums, rounding toward zero, and result select
  always_comb begin
    logic signed [32:0] s;
    logic signed [32:0] t;
    mat_t               mul;
    s2_d_next = $signed({in_data.prod[8][31], in_data.prod[8]})
              - $signed({in_data.prod[9][31], in_data.prod[9]});
    for (int k = 0; k < 4; k++) begin
      s = $signed({in_data.prod[2*k][31], in_data.prod[2*k]})
        + $signed({in_data.prod[2*k+1][31], in_data.prod[2*k+1]});
      t = s + (s[32] ? 33'sd255 : 33'sd0);
      mul[k] = sat16(34'(t >>> 8));
    end
    s2_num_next[0] = {in_data.a[3][15], in_data.a[3]};
    s2_num_next[1] = 17'(-$signed({in_data.a[1][15], in_data.a[1]}));
    s2_num_next[2] = 17'(-$signed({in_data.a[2][15], in_data.a[2]}));
    s2_num_next[3] = {in_data.a[0][15], in_data.a[0]};
    s2_inv_next = 1'b0;
    s2_res_next = '0;
    s2_det_next = '0;
    s2_ok_next  = 1'b1;
    case (in_data.cmd) inside
      CMD_ADD, CMD_SUB: s2_res_next = in_data.addsub;
      CMD_MUL:          s2_res_next = mul;
      CMD_DET:          s2_det_next = sat32(s2_d_next);
      CMD_INV: begin
        if (s2_d_next == 33'sd0) begin
          s2_ok_next = 1'b0;
        end else begin
          s2_inv_next = 1'b1;
          s2_det_next = sat32(s2_d_next);
        end
      end
      default:          s2_ok_next = 1'b0;
    endcase
  end

  // magnitudes and divider seed
  always_comb begin
    logic [32:0] dabs;
    logic [16:0] mag;
    dabs = s2_d[32] ? 33'(-s2_d) : s2_d;
    side_next.inv = s2_inv;
    side_next.res = s2_res;
    side_next.det = s2_det;
    side_next.ok  = s2_ok;
    side_next.dsr = dabs[31:0];
    for (int k = 0; k < 4; k++) begin
      mag = s2_num[k][16] ? 17'(-$signed(s2_num[k])) : s2_num[k];
      lanes_next[k].rem = {16'd0, mag[16:1]};
      lanes_next[k].dvd = {mag[0], 16'd0};
      lanes_next[k].quo = '0;
      lanes_next[k].neg = s2_num[k][16] ^ s2_d[32];
      lanes_next[k].ovf = ({16'd0, mag[16:1]} >= dabs[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= in_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_inv    <= s2_inv_next;
      s2_res    <= s2_res_next;
      s2_det    <= s2_det_next;
      s2_ok     <= s2_ok_next;
      s2_d      <= s2_d_next;
      s2_num    <= s2_num_next;
      out_side  <= side_next;
      out_lanes <= lanes_next;
    end
  end

endmodule

// ----- hdl/mau_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_div_step: one stage of the restoring divider
// Retires STEPS quotient bits in each of the four lanes, carrying the item.
// ----------------------------------------------------------------------------
module mau_div_step import mau_pkg::*; #(
  parameter int STEPS = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  side_t  in_side,
  input  lanes_t in_lanes,
  output logic   out_valid,
  output side_t  out_side,
  output lanes_t out_lanes
);

  lanes_t lanes_next;

  // shift, compare, subtract per quotient bit
  always_comb begin
    lane_t       l;
    logic [32:0] r2;
    for (int k = 0; k < 4; k++) begin
      l = in_lanes[k];
      for (int s = 0; s < STEPS; s++) begin
        r2    = {l.rem, l.dvd[16]};
        l.dvd = {l.dvd[15:0], 1'b0};
        if (r2 >= {1'b0, in_side.dsr}) begin
          l.rem = 32'(r2 - {1'b0, in_side.dsr});
          l.quo = {l.quo[15:0], 1'b1};
        end else begin
          l.rem = r2[31:0];
          l.quo = {l.quo[15:0], 1'b0};
        end
      end
      lanes_next[k] = l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side  <= in_side;
      out_lanes <= lanes_next;
    end
  end

endmodule
